// File: rtl/core/ttms_pkg.sv
// Shared types, codes and defaults for the task table scheduler.
package ttms_pkg;

   localparam int unsigned SLOTS_DEF = 16;
   localparam int unsigned CORES_DEF = 4;

   typedef enum logic [2:0] {
      CMD_ALLOC     = 3'd0,
      CMD_FREE      = 3'd1,
      CMD_SET_STATE = 3'd2,
      CMD_CHARGE    = 3'd3,
      CMD_PICK      = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      TS_RUNNING  = 2'd0,
      TS_SLEEPING = 2'd1,
      TS_STOPPED  = 2'd2,
      TS_INVALID  = 2'd3
   } task_state_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NONE      = 2'd1,
      STAT_BAD_STATE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_RMW,
      FSM_ALLOC,
      FSM_PICK,
      FSM_DONE
   } fsm_type;

   typedef struct packed {
      logic [31:0] runtime;
      logic [1:0]  state;
      logic        used;
   } entry_type;

endpackage

// File: rtl/core/ttms_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ttms_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/task_table_min_runtime_scheduler.sv
// Task slot table: allocate, free, set state, charge and least-runtime pick.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   req     | req_valid, req_stall, req_cmd .. ticks  | in
//   rsp     | rsp_valid, rsp_stall, rsp_status .. mask| out
//
// One word in, one word out. Free and rejected codes go straight to a result;
// set state and charge read the table and write it back. Allocate inspects
// slots in order until one is free, pick every CORES-th slot from its core;
// both walk the table one entry a cycle through the RAM read port. The next
// word is taken the cycle after its result enters the output register. Reset
// is synchronous and clears the per-slot valid bits, so the table reads as
// zero at once. A stalled result holds; work on a new word goes on behind it.
module task_table_min_runtime_scheduler #(
   parameter int unsigned SLOTS = ttms_pkg::SLOTS_DEF,
   parameter int unsigned CORES = ttms_pkg::CORES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic [3:0]  req_slot,
   input  logic [1:0]  req_new_state,
   input  logic [1:0]  req_core,
   input  logic [15:0] req_ticks,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_slot_out,
   output logic [4:0]  rsp_pid_out,
   output logic        rsp_idle,
   output logic [15:0] rsp_reclaimed_mask
);
   import ttms_pkg::*;

   localparam int unsigned AW = $clog2(SLOTS);
   localparam int unsigned SW = $clog2(SLOTS + CORES);
   localparam int unsigned EW = $bits(entry_type);

   fsm_type          state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [1:0]       nst_ff, nst_in;
   logic [15:0]      ticks_ff, ticks_in;
   logic [SW-1:0]    idx_ff, idx_in;
   logic [SLOTS-1:0] valid_ff, valid_in;
   logic             have_ff, have_in;
   logic [SW-1:0]    best_ff, best_in;
   logic [31:0]      best_rt_ff, best_rt_in;

   logic [1:0]  res_status_ff, res_status_in;
   logic [3:0]  res_slot_ff, res_slot_in;
   logic [4:0]  res_pid_ff, res_pid_in;
   logic        res_idle_ff, res_idle_in;
   logic [15:0] res_mask_ff, res_mask_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [3:0]  rsp_slot_ff, rsp_slot_in;
   logic [4:0]  rsp_pid_ff, rsp_pid_in;
   logic        rsp_idle_ff, rsp_idle_in;
   logic [15:0] rsp_mask_ff, rsp_mask_in;

   logic          ram_we;
   logic [AW-1:0] ram_wa, ram_ra;
   entry_type     ram_wd;
   logic [EW-1:0] ram_q;

   entry_type     cur;
   cmd_type       req_cmd_c;
   logic          accept, out_free, slot_ok, core_ok, ready, take;
   logic          step_end, jump_end;
   logic [SW-1:0] idx_step, idx_jump, sel;
   logic [32:0]   sum;

   ttms_ram #(
      .WIDTH(EW),
      .DEPTH(SLOTS)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_wa),
      .wr_data(ram_wd),
      .rd_addr(ram_ra),
      .rd_data(ram_q)
   );

   assign req_stall = (state_ff != FSM_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_cmd_c = cmd_type'(req_cmd);
   assign slot_ok   = (32'(req_slot) < SLOTS);
   assign core_ok   = (32'(req_core) < SLOTS);

   // entries never written since reset or free read as zero
   assign cur      = valid_ff[idx_ff[AW-1:0]] ? entry_type'(ram_q) : '0;
   assign ready    = cur.used && (cur.state == TS_RUNNING);
   assign take     = ready && (!have_ff || (cur.runtime < best_rt_ff));
   assign idx_step = idx_ff + SW'(1);
   assign idx_jump = idx_ff + SW'(CORES);
   assign step_end = (idx_step >= SW'(SLOTS));
   assign jump_end = (idx_jump >= SW'(SLOTS));
   assign sel      = take ? idx_ff : best_ff;
   assign sum      = 33'(cur.runtime) + 33'(ticks_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               case (req_cmd_c)
                  CMD_ALLOC:     state_in = FSM_ALLOC;
                  CMD_SET_STATE: state_in = (req_new_state != TS_INVALID && slot_ok) ?
                                            FSM_RMW : FSM_DONE;
                  CMD_CHARGE:    state_in = slot_ok ? FSM_RMW : FSM_DONE;
                  CMD_PICK:      state_in = core_ok ? FSM_PICK : FSM_DONE;
                  default:       state_in = FSM_DONE;
               endcase
            end
         end
         FSM_RMW:   state_in = FSM_DONE;
         FSM_ALLOC: begin
            if (!cur.used || step_end) begin
               state_in = FSM_DONE;
            end
         end
         FSM_PICK: begin
            if (jump_end) begin
               state_in = FSM_DONE;
            end
         end
         FSM_DONE: begin
            if (out_free) begin
               state_in = FSM_IDLE;
            end
         end
         default:   state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      cmd_in        = cmd_ff;
      nst_in        = nst_ff;
      ticks_in      = ticks_ff;
      idx_in        = idx_ff;
      valid_in      = valid_ff;
      have_in       = have_ff;
      best_in       = best_ff;
      best_rt_in    = best_rt_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_pid_in    = res_pid_ff;
      res_idle_in   = res_idle_ff;
      res_mask_in   = res_mask_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_pid_in    = rsp_pid_ff;
      rsp_idle_in   = rsp_idle_ff;
      rsp_mask_in   = rsp_mask_ff;
      ram_we        = 1'b0;
      ram_wa        = idx_ff[AW-1:0];
      ram_wd        = cur;
      ram_ra        = idx_step[AW-1:0];

      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               cmd_in        = req_cmd_c;
               nst_in        = req_new_state;
               ticks_in      = req_ticks;
               have_in       = 1'b0;
               res_status_in = STAT_OK;
               res_slot_in   = '0;
               res_pid_in    = '0;
               res_idle_in   = 1'b0;
               res_mask_in   = '0;
               case (req_cmd_c)
                  CMD_ALLOC: begin
                     idx_in = '0;
                     ram_ra = '0;
                  end
                  CMD_FREE: begin
                     if (slot_ok) begin
                        valid_in[AW'(req_slot)] = 1'b0;
                     end
                  end
                  CMD_SET_STATE, CMD_CHARGE: begin
                     idx_in = SW'(req_slot);
                     ram_ra = AW'(req_slot);
                     if (req_cmd_c == CMD_SET_STATE && req_new_state == TS_INVALID) begin
                        res_status_in = STAT_BAD_STATE;
                     end
                  end
                  CMD_PICK: begin
                     idx_in = SW'(req_core);
                     ram_ra = AW'(req_core);
                     if (!core_ok) begin
                        res_status_in = STAT_NONE;
                        res_idle_in   = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         FSM_RMW: begin
            ram_we = 1'b1;
            if (cmd_ff == CMD_SET_STATE) begin
               ram_wd.state = nst_ff;
            end else begin
               ram_wd.runtime = sum[32] ? '1 : sum[31:0];
            end
            valid_in[idx_ff[AW-1:0]] = 1'b1;
         end
         FSM_ALLOC: begin
            idx_in = idx_step;
            if (!cur.used) begin
               ram_we                   = 1'b1;
               ram_wd.used              = 1'b1;
               valid_in[idx_ff[AW-1:0]] = 1'b1;
               res_slot_in              = 4'(idx_ff);
               res_pid_in               = 5'(idx_step);
            end else begin
               if (cur.state == TS_STOPPED) begin
                  valid_in[idx_ff[AW-1:0]] = 1'b0;
                  res_mask_in              = res_mask_ff | (16'(1) << idx_ff);
               end
               if (step_end) begin
                  res_status_in = STAT_NONE;
               end
            end
         end
         FSM_PICK: begin
            idx_in = idx_jump;
            ram_ra = idx_jump[AW-1:0];
            if (take) begin
               have_in    = 1'b1;
               best_in    = idx_ff;
               best_rt_in = cur.runtime;
            end
            if (jump_end) begin
               if (take || have_ff) begin
                  res_slot_in = 4'(sel);
                  res_pid_in  = 5'(sel + SW'(1));
               end else begin
                  res_status_in = STAT_NONE;
                  res_idle_in   = 1'b1;
               end
            end
         end
         FSM_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_pid_in    = res_pid_ff;
               rsp_idle_in   = res_idle_ff;
               rsp_mask_in   = res_mask_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      nst_ff        <= nst_in;
      ticks_ff      <= ticks_in;
      idx_ff        <= idx_in;
      have_ff       <= have_in;
      best_ff       <= best_in;
      best_rt_ff    <= best_rt_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_pid_ff    <= res_pid_in;
      res_idle_ff   <= res_idle_in;
      res_mask_ff   <= res_mask_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_pid_ff    <= rsp_pid_in;
      rsp_idle_ff   <= rsp_idle_in;
      rsp_mask_ff   <= rsp_mask_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_slot_out       = rsp_slot_ff;
   assign rsp_pid_out        = rsp_pid_ff;
   assign rsp_idle           = rsp_idle_ff;
   assign rsp_reclaimed_mask = rsp_mask_ff;

endmodule

// File: sim/tb.sv
// Testbench for the task table scheduler: directed table, random commands, self-checking.
module tb;
   import ttms_pkg::*;

   localparam int NSLOTS = SLOTS_DEF;
   localparam int NCORES = CORES_DEF;
   localparam int RANDOM_WORDS = 700;
   // a run of large charges on one live slot before picking against it
   localparam int BIG_CHARGES = 40;
   localparam int HOLD_CYCLES = 400;
   localparam logic [2:0] CMD_SPARE_5 = 3'd5;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [3:0]  slot;
      logic [1:0]  nst;
      logic [1:0]  core;
      logic [15:0] ticks;
   } command_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  slot_out;
      logic [4:0]  pid;
      logic        idle;
      logic [15:0] mask;
   } reply_type;

   typedef struct {
      command_type c;
      bit          typed;
      reply_type   reply;
   } script_entry_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_cmd = '0;
   logic [3:0]  req_slot = '0;
   logic [1:0]  req_new_state = '0;
   logic [1:0]  req_core = '0;
   logic [15:0] req_ticks = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_slot_out;
   logic [4:0]  rsp_pid_out;
   logic        rsp_idle;
   logic [15:0] rsp_reclaimed_mask;

   logic        slot_busy [NSLOTS];
   logic [1:0]  slot_mode [NSLOTS];
   logic [31:0] slot_ticks [NSLOTS];

   reply_type          owed_replies[$];
   script_entry_type   script[$];
   int                 errors = 0;
   int                 replies_seen = 0;
   int                 hold_left = 0;
   bit                 sender_calm = 1'b0;

   task_table_min_runtime_scheduler #(.SLOTS(NSLOTS), .CORES(NCORES)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_slot(req_slot),
      .req_new_state(req_new_state),
      .req_core(req_core),
      .req_ticks(req_ticks),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_slot_out(rsp_slot_out),
      .rsp_pid_out(rsp_pid_out),
      .rsp_idle(rsp_idle),
      .rsp_reclaimed_mask(rsp_reclaimed_mask)
   );

   always #4 clock = ~clock;

   function automatic reply_type apply_command(input command_type c);
      reply_type   r;
      bit          found;
      logic [31:0] best_rt;
      logic [32:0] sum;
      r = '0;
      found = 1'b0;
      best_rt = '0;
      case (c.cmd)
         CMD_ALLOC: begin
            for (int i = 0; i < NSLOTS; i++) begin
               if (!found) begin
                  if (!slot_busy[i]) begin
                     slot_busy[i] = 1'b1;
                     r.slot_out = 4'(i);
                     r.pid = 5'(i + 1);
                     found = 1'b1;
                  end else if (slot_mode[i] == TS_STOPPED) begin
                     slot_busy[i] = 1'b0;
                     slot_mode[i] = TS_RUNNING;
                     slot_ticks[i] = '0;
                     if (i < $bits(r.mask)) r.mask[i] = 1'b1;
                  end
               end
            end
            if (!found) r.status = STAT_NONE;
         end
         CMD_FREE: begin
            if (c.slot < NSLOTS) begin
               slot_busy[c.slot] = 1'b0;
               slot_mode[c.slot] = TS_RUNNING;
               slot_ticks[c.slot] = '0;
            end
         end
         CMD_SET_STATE: begin
            if (c.nst == TS_INVALID) r.status = STAT_BAD_STATE;
            else if (c.slot < NSLOTS) slot_mode[c.slot] = c.nst;
         end
         CMD_CHARGE: begin
            if (c.slot < NSLOTS) begin
               sum = {1'b0, slot_ticks[c.slot]} + 33'(c.ticks);
               slot_ticks[c.slot] = sum[32] ? '1 : sum[31:0];
            end
         end
         CMD_PICK: begin
            for (int i = int'(c.core); i < NSLOTS; i += NCORES) begin
               if (slot_busy[i] && slot_mode[i] == TS_RUNNING &&
                   (!found || slot_ticks[i] < best_rt)) begin
                  found = 1'b1;
                  best_rt = slot_ticks[i];
                  r.slot_out = 4'(i);
                  r.pid = 5'(i + 1);
               end
            end
            if (!found) begin
               r.status = STAT_NONE;
               r.idle = 1'b1;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic script_entry_type script_row(
      input logic [2:0] cmd, input logic [3:0] slot, input logic [1:0] nst,
      input logic [1:0] core, input logic [15:0] ticks, input bit typed,
      input logic [1:0] status = STAT_OK, input logic [3:0] slot_out = '0,
      input logic [4:0] pid = '0, input logic idle = 1'b0, input logic [15:0] mask = '0);
      script_entry_type e;
      e.c = '{cmd: cmd, slot: slot, nst: nst, core: core, ticks: ticks};
      e.typed = typed;
      e.reply = '{status: status, slot_out: slot_out, pid: pid, idle: idle, mask: mask};
      return e;
   endfunction

   function automatic command_type random_command();
      command_type c;
      int          roll;
      c.slot = 4'($urandom_range(15));
      c.core = 2'($urandom_range(3));
      c.nst = 2'($urandom_range(3));
      c.ticks = 16'($urandom_range(16'hFFFF));
      roll = $urandom_range(99);
      if (roll < 22) c.cmd = CMD_ALLOC;
      else if (roll < 30) c.cmd = CMD_FREE;
      else if (roll < 50) begin
         c.cmd = CMD_SET_STATE;
         roll = $urandom_range(9);
         if (roll < 4) c.nst = TS_RUNNING;
         else if (roll < 6) c.nst = TS_SLEEPING;
         else if (roll < 9) c.nst = TS_STOPPED;
         else c.nst = TS_INVALID;
      end else if (roll < 70) begin
         c.cmd = CMD_CHARGE;
         roll = $urandom_range(7);
         if (roll == 0) c.ticks = '0;
         else if (roll == 1) c.ticks = '1;
         else if (roll < 5) c.ticks = 16'($urandom_range(3));
      end else if (roll < 95) c.cmd = CMD_PICK;
      else c.cmd = 3'($urandom_range(CMD_SPARE_7, CMD_SPARE_5));
      return c;
   endfunction

   task automatic offer(input command_type c, input bit typed, input reply_type want);
      reply_type r;
      req_valid <= 1'b1;
      req_cmd <= c.cmd;
      req_slot <= c.slot;
      req_new_state <= c.nst;
      req_core <= c.core;
      req_ticks <= c.ticks;
      do @(posedge clock); while (req_stall);
      r = apply_command(c);
      owed_replies.push_back(typed ? want : r);
   endtask

   task automatic maybe_gap();
      if (!sender_calm && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 60);
      end
   endtask

   task automatic wait_for_replies();
      req_valid <= 1'b0;
      do @(posedge clock); while (owed_replies.size() != 0);
   endtask

   task automatic check_field(input string name, input logic [31:0] want_v, got_v);
      if (want_v !== got_v) begin
         errors++;
         if (errors <= 50) $error("%s: expected %0d, got %0d", name, want_v, got_v);
      end
   endtask

   always @(posedge clock) begin : reply_side
      reply_type want;
      if (rsp_valid === 1'b1 && !rsp_stall) begin
         replies_seen++;
         if (owed_replies.size() == 0) begin
            errors++;
            if (errors <= 50) $error("reply word with nothing outstanding");
         end else begin
            want = owed_replies.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("slot_out", 32'(want.slot_out), 32'(rsp_slot_out));
            check_field("pid_out", 32'(want.pid), 32'(rsp_pid_out));
            check_field("idle", 32'(want.idle), 32'(rsp_idle));
            check_field("reclaimed_mask", 32'(want.mask), 32'(rsp_reclaimed_mask));
         end
         // long back-pressure so the result holds and the request side stalls
         if (replies_seen == 200) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (replies_seen >= 500 && replies_seen < 700) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 14);
      end
   end

   initial begin : stimulus
      reply_type none;
      int        busy_slot;
      none = '0;
      busy_slot = 0;
      for (int i = 0; i < NSLOTS; i++) begin
         slot_busy[i] = 1'b0;
         slot_mode[i] = TS_RUNNING;
         slot_ticks[i] = '0;
      end

      script.push_back(script_row(CMD_PICK, 0, TS_RUNNING, 0, 0, 1, STAT_NONE, 0, 0, 1));
      script.push_back(script_row(CMD_PICK, 0, TS_RUNNING, 3, 0, 1, STAT_NONE, 0, 0, 1));
      script.push_back(script_row(CMD_ALLOC, 0, TS_RUNNING, 0, 0, 1, STAT_OK, 0, 1));
      script.push_back(script_row(CMD_ALLOC, 0, TS_RUNNING, 0, 0, 1, STAT_OK, 1, 2));
      script.push_back(script_row(CMD_SET_STATE, 0, TS_INVALID, 0, 0, 1, STAT_BAD_STATE));
      script.push_back(script_row(CMD_SET_STATE, 15, TS_INVALID, 3, 0, 1, STAT_BAD_STATE));
      script.push_back(script_row(CMD_SET_STATE, 0, TS_STOPPED, 0, 0, 1, STAT_OK));
      script.push_back(script_row(CMD_SET_STATE, 15, TS_SLEEPING, 0, 0, 1, STAT_OK));
      script.push_back(script_row(CMD_CHARGE, 1, TS_RUNNING, 0, 16'hFFFF, 1, STAT_OK));
      script.push_back(script_row(CMD_CHARGE, 1, TS_RUNNING, 0, 16'h0000, 1, STAT_OK));
      // stopped slot 0 is reclaimed on the way, slot 2 is taken
      script.push_back(script_row(CMD_ALLOC, 0, TS_RUNNING, 0, 0, 1, STAT_OK, 2, 3, 0,
                                  16'h0001));
      script.push_back(script_row(CMD_ALLOC, 0, TS_RUNNING, 0, 0, 1, STAT_OK, 0, 1));
      script.push_back(script_row(CMD_PICK, 0, TS_RUNNING, 1, 0, 1, STAT_OK, 1, 2));
      script.push_back(script_row(CMD_PICK, 0, TS_RUNNING, 0, 0, 1, STAT_OK, 0, 1));
      script.push_back(script_row(CMD_CHARGE, 0, TS_RUNNING, 0, 16'h0003, 1, STAT_OK));
      script.push_back(script_row(CMD_ALLOC, 0, TS_RUNNING, 0, 0, 1, STAT_OK, 3, 4));
      script.push_back(script_row(CMD_ALLOC, 0, TS_RUNNING, 0, 0, 1, STAT_OK, 4, 5));
      script.push_back(script_row(CMD_PICK, 0, TS_RUNNING, 0, 0, 0));
      script.push_back(script_row(CMD_CHARGE, 4, TS_RUNNING, 0, 16'h0003, 1, STAT_OK));
      // equal runtimes: earliest slot wins
      script.push_back(script_row(CMD_PICK, 0, TS_RUNNING, 0, 0, 0));
      script.push_back(script_row(CMD_FREE, 0, TS_RUNNING, 0, 0, 1, STAT_OK));
      script.push_back(script_row(CMD_PICK, 0, TS_RUNNING, 0, 0, 0));
      script.push_back(script_row(CMD_FREE, 15, TS_RUNNING, 0, 0, 1, STAT_OK));
      script.push_back(script_row(CMD_SPARE_7, 15, TS_INVALID, 3, 16'hFFFF, 1));
      script.push_back(script_row(CMD_SPARE_5, 0, TS_RUNNING, 0, 0, 1));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         offer(script[i].c, script[i].typed, script[i].reply);
         maybe_gap();
      end

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         sender_calm = (n >= 250 && n < 400);
         if (n == 500) wait_for_replies();
         offer(random_command(), 1'b0, none);
         maybe_gap();
      end
      sender_calm = 1'b0;
      wait_for_replies();

      // load one live slot with large charges, then pick against it
      for (int i = NSLOTS - 1; i >= 0; i--)
         if (slot_busy[i]) busy_slot = i;
      offer('{cmd: CMD_SET_STATE, slot: 4'(busy_slot), nst: TS_RUNNING, core: 0, ticks: 0},
            1'b0, none);
      sender_calm = 1'b1;
      for (int n = 0; n < BIG_CHARGES; n++)
         offer('{cmd: CMD_CHARGE, slot: 4'(busy_slot), nst: 0, core: 0, ticks: 16'hFFFF},
               1'b0, none);
      sender_calm = 1'b0;
      for (int k = 0; k < NCORES; k++) begin
         offer('{cmd: CMD_PICK, slot: 0, nst: 0, core: 2'(k), ticks: 0}, 1'b0, none);
         maybe_gap();
      end
      for (int n = 0; n < 40; n++) begin
         offer(random_command(), 1'b0, none);
         maybe_gap();
      end

      wait_for_replies();
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin : watchdog
      #40000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
